// ===== design/captg_pkg.sv =====
// Package with shared types and constants of the Clifford attractor point generator.
package captg_pkg;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_COEF_A      = 3'd0,
		REG_COEF_B      = 3'd1,
		REG_COEF_C      = 3'd2,
		REG_COEF_D      = 3'd3,
		REG_START_X     = 3'd4,
		REG_START_Y     = 3'd5,
		REG_POINT_COUNT = 3'd6
	} reg_idx_t;

	// Main sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SC_START,
		ST_SC_WAIT,
		ST_MUL_SIN,
		ST_MUL_COS,
		ST_SUM,
		ST_DELTA,
		ST_SQ_START,
		ST_SQ_WAIT,
		ST_OUT
	} state_t;

	// Sine/cosine unit states.
	typedef enum logic [2:0] {
		SC_IDLE,
		SC_REDUCE1,
		SC_REDUCE2,
		SC_ROTATE,
		SC_FOLD
	} sc_state_t;

	localparam logic [31:0] TWO_OVER_PI_Q30 = 32'd683565276;
	localparam logic [31:0] PI_HALF_Q30     = 32'd1686629713;
	localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
	localparam logic [18:0] MAX_RUN = 19'd262144;

	// Arctangent table in Q30 radians.
	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  atan_q30 = 34'sd843314857;
			5'd1:  atan_q30 = 34'sd497837829;
			5'd2:  atan_q30 = 34'sd263043837;
			5'd3:  atan_q30 = 34'sd133525159;
			5'd4:  atan_q30 = 34'sd67021687;
			5'd5:  atan_q30 = 34'sd33543516;
			5'd6:  atan_q30 = 34'sd16775851;
			5'd7:  atan_q30 = 34'sd8388437;
			5'd8:  atan_q30 = 34'sd4194283;
			5'd9:  atan_q30 = 34'sd2097149;
			5'd10: atan_q30 = 34'sd1048576;
			5'd11: atan_q30 = 34'sd524288;
			5'd12: atan_q30 = 34'sd262144;
			5'd13: atan_q30 = 34'sd131072;
			5'd14: atan_q30 = 34'sd65536;
			5'd15: atan_q30 = 34'sd32768;
			5'd16: atan_q30 = 34'sd16384;
			5'd17: atan_q30 = 34'sd8192;
			5'd18: atan_q30 = 34'sd4096;
			5'd19: atan_q30 = 34'sd2048;
			5'd20: atan_q30 = 34'sd1024;
			5'd21: atan_q30 = 34'sd512;
			5'd22: atan_q30 = 34'sd256;
			5'd23: atan_q30 = 34'sd128;
			default: atan_q30 = 34'sd0;
		endcase
	endfunction

endpackage

// ===== design/captg_sincos.sv =====
// Iterative CORDIC unit that returns sine and cosine of a fixed-point argument.
module captg_sincos #(
	parameter int FRAC_BITS    = 12,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] arg,
	output logic               done,
	output logic signed [33:0] sin_out,
	output logic signed [33:0] cos_out
);
	import captg_pkg::*;

	localparam int SH = 2 * FRAC_BITS - 2;

	sc_state_t state_q;
	logic        neg_q;
	logic [31:0] mag_q;
	logic [33:0] t_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [4:0]  step_q;
	logic [63:0] prod;
	logic [64:0] rounded;
	logic [63:0] zprod;
	logic signed [33:0] dx, dy, s_f, c_f;

	// Products for the two range-reduction states and the shift terms of the rotation.
	always_comb begin
		prod = 64'(mag_q) * 64'(TWO_OVER_PI_Q30);
		rounded = 65'(prod) + (65'd1 << (SH - 1));
		zprod = 64'(t_q[31:0]) * 64'(PI_HALF_Q30);
		dx = y_q >>> step_q;
		dy = x_q >>> step_q;
	end

	// Quadrant fold of the rotated vector.
	always_comb begin
		case (t_q[33:32])
			2'd0: begin c_f = x_q;  s_f = y_q;  end
			2'd1: begin c_f = -y_q; s_f = x_q;  end
			2'd2: begin c_f = -x_q; s_f = -y_q; end
			default: begin c_f = y_q; s_f = -x_q; end
		endcase
	end

	// Sequencer and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				SC_IDLE: begin
					if (start) begin
						neg_q   <= arg[31];
						mag_q   <= arg[31] ? 32'(-arg) : 32'(arg);
						state_q <= SC_REDUCE1;
					end
				end
				SC_REDUCE1: begin
					t_q     <= 34'(rounded >> SH);
					state_q <= SC_REDUCE2;
				end
				SC_REDUCE2: begin
					z_q     <= $signed({2'b00, zprod[63:32]});
					x_q     <= CORDIC_GAIN_INV;
					y_q     <= '0;
					step_q  <= '0;
					state_q <= SC_ROTATE;
				end
				SC_ROTATE: begin
					if (!z_q[33]) begin
						x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - atan_q30(step_q);
					end else begin
						x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + atan_q30(step_q);
					end
					step_q <= step_q + 5'd1;
					if (32'(step_q) == CORDIC_STEPS - 1) state_q <= SC_FOLD;
				end
				SC_FOLD: begin
					sin_out <= neg_q ? -s_f : s_f;
					cos_out <= c_f;
					done    <= 1'b1;
					state_q <= SC_IDLE;
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("sincos done held");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SC_ROTATE) |-> (32'(step_q) < CORDIC_STEPS))
		else $error("cordic step overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == SC_FOLD)
		else $error("done outside fold");
endmodule

// ===== design/captg_isqrt.sv =====
// Iterative rounded integer square root, one result bit per cycle.
module captg_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] radicand,
	output logic        done,
	output logic [16:0] root
);
	import captg_pkg::*;

	logic        busy_q;
	logic [32:0] n_q, s_q;
	logic [33:0] r_q, bit_q;
	logic [33:0] trial;
	logic [33:0] rem;

	always_comb begin
		trial = r_q + bit_q;
		rem = 34'(s_q) - r_q * r_q;
	end

	// Digit-by-digit root, then round to nearest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= radicand;
				s_q    <= radicand;
				r_q    <= '0;
				bit_q  <= 34'd1 << 32;
			end else if (busy_q) begin
				if (bit_q == 0) begin
					root   <= 17'(r_q) + 17'(rem > r_q);
					done   <= 1'b1;
					busy_q <= 1'b0;
				end else begin
					if (34'(n_q) >= trial) begin
						n_q <= 33'(34'(n_q) - trial);
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("isqrt done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("isqrt did not start");
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(bit_q) || !busy_q)
		else $error("isqrt bit not one-hot");
endmodule

// ===== design/clifford_attractor_point_generator.sv =====
// Clifford attractor point generator: one step per request, Q4.12 fixed point, CORDIC sin/cos.
// Each accepted request runs four sine/cosine passes on one shared CORDIC unit. A pass is
// start, range reduction, CORDIC_STEPS rotations, folding and handshake; a cosine pass then
// also accumulates the new coordinate. A jump stage with the square root follows. The block
// takes no new request until the result has been taken. The user must write configuration
// over the APB port only while idle; the block itself does not enforce this.
module clifford_attractor_point_generator #(
	parameter int FRAC_BITS    = 12,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] point_x,
	output logic signed [15:0] point_y,
	output logic [15:0]        jump_length,
	output logic               last_point
);
	import captg_pkg::*;

	logic signed [15:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q, start_x_q, start_y_q;
	logic [18:0] point_count_q;
	logic signed [15:0] cur_x_q, cur_y_q, new_x_q, new_y_q;
	logic [17:0] done_cnt_q;
	state_t state_q, state_d;
	logic [1:0] pass_q;
	logic signed [31:0] sc_arg;
	logic sc_start, sc_done, sq_start, sq_done;
	logic signed [33:0] sc_sin, sc_cos;
	logic signed [33:0] sin_keep_q;
	logic signed [49:0] acc_q;
	logic signed [15:0] mul_k, mul_c, mul_u;
	logic signed [31:0] mul_p;
	logic signed [16:0] dx_q, dy_q;
	logic [32:0] sumsq;
	logic [16:0] root;
	logic [18:0] run_len;
	logic signed [49:0] rnd;
	logic signed [15:0] sat_v;
	logic wr_en;
	reg_idx_t widx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign widx   = reg_idx_t'(paddr[4:2]);

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= -16'sd6963;  coef_b_q <= 16'sd7373;
			coef_c_q <= -16'sd7782;  coef_d_q <= -16'sd1638;
			start_x_q <= 16'sd410;   start_y_q <= 16'sd410;
			point_count_q <= 19'd200000;
		end else if (wr_en) begin
			case (widx)
				REG_COEF_A:      coef_a_q <= pwdata[15:0];
				REG_COEF_B:      coef_b_q <= pwdata[15:0];
				REG_COEF_C:      coef_c_q <= pwdata[15:0];
				REG_COEF_D:      coef_d_q <= pwdata[15:0];
				REG_START_X:     start_x_q <= pwdata[15:0];
				REG_START_Y:     start_y_q <= pwdata[15:0];
				REG_POINT_COUNT: point_count_q <= pwdata[18:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (widx)
			REG_COEF_A:      prdata = 32'(signed'(coef_a_q));
			REG_COEF_B:      prdata = 32'(signed'(coef_b_q));
			REG_COEF_C:      prdata = 32'(signed'(coef_c_q));
			REG_COEF_D:      prdata = 32'(signed'(coef_d_q));
			REG_START_X:     prdata = 32'(signed'(start_x_q));
			REG_START_Y:     prdata = 32'(signed'(start_y_q));
			REG_POINT_COUNT: prdata = 32'(point_count_q);
			default:         prdata = '0;
		endcase
	end

	// Pass 0: sin(a*y), 1: cos(a*x), 2: sin(b*x), 3: cos(b*y).
	always_comb begin
		mul_k = pass_q[1] ? coef_b_q : coef_a_q;
		mul_c = pass_q[1] ? coef_d_q : coef_c_q;
		case (pass_q)
			2'd0:    mul_u = cur_y_q;
			2'd1:    mul_u = cur_x_q;
			2'd2:    mul_u = cur_x_q;
			default: mul_u = cur_y_q;
		endcase
		mul_p  = mul_k * mul_u;
		sc_arg = mul_p;
		rnd    = (acc_q + (50'sd1 <<< 29)) >>> 30;
		if (rnd > 50'sd32767)       sat_v = 16'sh7fff;
		else if (rnd < -50'sd32768) sat_v = -16'sh8000;
		else                        sat_v = 16'(rnd);
		sumsq   = 33'(dx_q * dx_q) + 33'(dy_q * dy_q);
		if (point_count_q == 0)            run_len = 19'd1;
		else if (point_count_q > MAX_RUN) run_len = MAX_RUN;
		else                               run_len = point_count_q;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_SC_START;
			ST_SC_START: state_d = ST_SC_WAIT;
			ST_SC_WAIT:  if (sc_done) state_d = pass_q[0] ? ST_MUL_COS : ST_MUL_SIN;
			ST_MUL_SIN:  state_d = ST_SC_START;
			ST_MUL_COS:  state_d = ST_SUM;
			ST_SUM:      state_d = (pass_q == 2'd3) ? ST_DELTA : ST_SC_START;
			ST_DELTA:    state_d = ST_SQ_START;
			ST_SQ_START: state_d = ST_SQ_WAIT;
			ST_SQ_WAIT:  if (sq_done) state_d = ST_OUT;
			ST_OUT:      if (out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Output decode.
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		sc_start  = (state_q == ST_SC_START);
		sq_start  = (state_q == ST_SQ_START);
	end

	// Datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pass_q     <= '0;
			cur_x_q    <= 16'sd410;
			cur_y_q    <= 16'sd410;
			done_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					pass_q <= '0;
					if (in_valid && restart) begin
						cur_x_q <= start_x_q; cur_y_q <= start_y_q; done_cnt_q <= '0;
					end
				end
				// Only the sine passes keep their result for the following cosine pass.
				ST_SC_WAIT: if (sc_done && !pass_q[0]) sin_keep_q <= sc_sin;
				ST_MUL_SIN: pass_q <= pass_q + 2'd1;
				ST_MUL_COS: acc_q <= 50'(sin_keep_q) * (50'sd1 <<< FRAC_BITS)
					+ 50'(sc_cos) * 50'(mul_c);
				ST_SUM: begin
					if (pass_q == 2'd1) new_x_q <= sat_v;
					else new_y_q <= sat_v;
					pass_q <= pass_q + 2'd1;
				end
				ST_DELTA: begin
					dx_q <= 17'(new_x_q) - 17'(cur_x_q);
					dy_q <= 17'(new_y_q) - 17'(cur_y_q);
					point_x <= new_x_q;
					point_y <= new_y_q;
					last_point <= (19'(done_cnt_q) + 19'd1 >= run_len);
				end
				ST_SQ_WAIT: if (sq_done) jump_length <= root[16] ? 16'hffff : root[15:0];
				ST_OUT: if (out_ready) begin
					if (last_point) begin
						cur_x_q <= start_x_q; cur_y_q <= start_y_q; done_cnt_q <= '0;
					end else begin
						cur_x_q <= point_x; cur_y_q <= point_y;
						done_cnt_q <= done_cnt_q + 18'd1;
					end
				end
				default: ;
			endcase
		end
	end

	captg_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sincos (
		.clk(clk), .arst_n(arst_n), .start(sc_start), .arg(sc_arg),
		.done(sc_done), .sin_out(sc_sin), .cos_out(sc_cos)
	);

	captg_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sumsq),
		.done(sq_done), .root(root)
	);

	assert property (@(posedge clk) disable iff (!arst_n) in_ready |-> !out_valid)
		else $error("ready while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(point_x))
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_point) |=> done_cnt_q == 0)
		else $error("run not restarted");
endmodule

// ===== test/captg_checker.sv =====
// Checker that predicts each Clifford attractor point and compares it with the block's output.
`timescale 1ns / 100ps

module captg_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               restart,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic [15:0]        jump_length,
	input  logic               last_point,
	output int                 errors,
	output int                 pending,
	output int                 accepted
);
	import captg_pkg::*;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        len;
		logic               last;
	} point_t;

	localparam longint ARCTAN[16] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768
	};

	// Shadow copy of the registers and the walk state.
	logic signed [15:0] coef_a, coef_b, coef_c, coef_d, start_x, start_y;
	logic [18:0]        point_count;
	logic signed [15:0] pos_x, pos_y;
	logic [17:0]        done_cnt;
	point_t             expected_points[$];

	// Sine and cosine in Q30 of an argument with 24 fraction bits.
	function automatic void sine_cosine(input longint p, output longint s, output longint c);
		bit                neg;
		longint unsigned   m, t, frac;
		logic [1:0]        quad;
		longint            x, y, z, dx, dy, ts, tc;
		neg = p < 0;
		m = neg ? longint'(-p) : p;
		t = (m * 64'(TWO_OVER_PI_Q30) + (64'd1 << 21)) >> 22;
		quad = t[33:32];
		frac = t & 64'hFFFF_FFFF;
		z = longint'((frac * 64'(PI_HALF_Q30)) >> 32);
		x = CORDIC_GAIN_INV;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARCTAN[i];
			end else begin
				x += dx; y -= dy; z += ARCTAN[i];
			end
		end
		case (quad)
			2'd0: begin tc = x;  ts = y;  end
			2'd1: begin tc = -y; ts = x;  end
			2'd2: begin tc = -x; ts = -y; end
			default: begin tc = y; ts = -x; end
		endcase
		s = neg ? -ts : ts;
		c = tc;
	endfunction

	// One coordinate update: sin(k*v) + mul*cos(k*u), rounded and saturated.
	function automatic longint next_coord(input longint k, input longint u, input longint v,
			input longint mul);
		longint s1, c1, s2, c2, sum, r;
		sine_cosine(k * v, s1, c1);
		sine_cosine(k * u, s2, c2);
		sum = s1 * 4096 + mul * c2;
		r = (sum + (64'sd1 << 29)) >>> 30;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r;
	endfunction

	// Integer square root rounded to nearest.
	function automatic longint unsigned root_nearest(input longint unsigned sq);
		longint unsigned r, b, n;
		r = 0;
		b = 64'd1 << 62;
		n = sq;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (sq - r * r > r) r++;
		return r;
	endfunction

	// Advance the walk by one request and return the point it yields.
	function automatic point_t step_walk(input logic rst);
		point_t          pt;
		longint          run, nx, ny, dx, dy;
		longint unsigned len;
		run = point_count;
		if (run == 0) run = 1;
		if (run > MAX_RUN) run = MAX_RUN;
		if (rst) begin
			pos_x = start_x; pos_y = start_y; done_cnt = '0;
		end
		nx = next_coord(coef_a, pos_x, pos_y, coef_c);
		ny = next_coord(coef_b, pos_y, pos_x, coef_d);
		dx = nx - pos_x;
		dy = ny - pos_y;
		len = root_nearest(longint'(dx * dx) + longint'(dy * dy));
		if (len > 65535) len = 65535;
		pt.x = 16'(nx);
		pt.y = 16'(ny);
		pt.len = 16'(len);
		pt.last = (longint'(done_cnt) + 1 >= run);
		if (pt.last) begin
			pos_x = start_x; pos_y = start_y; done_cnt = '0;
		end else begin
			pos_x = 16'(nx); pos_y = 16'(ny); done_cnt = done_cnt + 1'b1;
		end
		return pt;
	endfunction

	// Track register writes, predict on each request and compare each result.
	always @(posedge clk or negedge arst_n) begin
		point_t want;
		int     bad;
		if (!arst_n) begin
			coef_a <= -16'sd6963; coef_b <= 16'sd7373;
			coef_c <= -16'sd7782; coef_d <= -16'sd1638;
			start_x <= 16'sd410; start_y <= 16'sd410;
			point_count <= 19'd200000;
			pos_x = 16'sd410; pos_y = 16'sd410; done_cnt = '0;
			expected_points.delete();
			errors <= 0;
			accepted <= 0;
			pending <= 0;
		end else begin
			bad = 0;
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_COEF_A:      coef_a <= pwdata[15:0];
					REG_COEF_B:      coef_b <= pwdata[15:0];
					REG_COEF_C:      coef_c <= pwdata[15:0];
					REG_COEF_D:      coef_d <= pwdata[15:0];
					REG_START_X:     start_x <= pwdata[15:0];
					REG_START_Y:     start_y <= pwdata[15:0];
					REG_POINT_COUNT: point_count <= pwdata[18:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					$error("result with no request waiting");
					bad++;
				end else begin
					want = expected_points.pop_front();
					if (point_x !== want.x) begin
						$error("point_x expected %0d got %0d", want.x, point_x);
						bad++;
					end
					if (point_y !== want.y) begin
						$error("point_y expected %0d got %0d", want.y, point_y);
						bad++;
					end
					if (jump_length !== want.len) begin
						$error("jump_length expected %0d got %0d", want.len, jump_length);
						bad++;
					end
					if (last_point !== want.last) begin
						$error("last_point expected %0d got %0d", want.last, last_point);
						bad++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_points = {expected_points, step_walk(restart)};
				accepted <= accepted + 1;
			end
			errors <= errors + bad;
			pending <= expected_points.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
// Top of the testbench: stimulus, configuration writes, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;
	import captg_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic               clk, arst_n;
	logic               psel, penable, pwrite, pready;
	logic [4:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               in_valid, in_ready, restart;
	logic               out_valid, out_ready;
	logic signed [15:0] point_x, point_y;
	logic [15:0]        jump_length;
	logic               last_point;
	int                 errors, pending, accepted;
	int                 send_idle_pct, recv_stall_pct;
	int                 quiet_cycles = 0;
	bit                 hold_off;

	clifford_attractor_point_generator dut (.*);

	captg_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, with one long hold-off.
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog on cycles with no traffic at all.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// One register write over the configuration port.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= {idx, 2'b00}; pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(negedge clk);
	endtask

	task automatic write_all(input int a, input int b, input int c, input int d,
			input int sx, input int sy, input int cnt);
		write_reg(REG_COEF_A, a);
		write_reg(REG_COEF_B, b);
		write_reg(REG_COEF_C, c);
		write_reg(REG_COEF_D, d);
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_POINT_COUNT, cnt);
	endtask

	// Offer one step request and wait until it is taken.
	task automatic send_step(input logic rst);
		int target;
		target = accepted + 1;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		restart <= rst;
		do @(negedge clk); while (accepted != target);
	endtask

	// Stop offering and let every outstanding point come back.
	task automatic drain;
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic int rand16;
		return $signed(16'($urandom));
	endfunction

	initial begin
		int cnt;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_valid = 0; restart = 0;
		send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: reset settings, plain step and restart.
		send_step(0); send_step(0); send_step(1); send_step(0);
		drain();
		// Extreme coefficients and start point, zero count means every point is last.
		write_all(-32768, 32767, 32767, -32768, 32767, -32768, 0);
		send_step(0); send_step(1); send_step(0);
		drain();
		// Count of one, then two with a restart landing on the last point.
		write_all(32767, -32768, -32768, 32767, -32768, 32767, 1);
		send_step(0); send_step(1);
		drain();
		write_all(0, 0, 0, 0, 0, 0, 2);
		send_step(0); send_step(1); send_step(0); send_step(0);
		drain();
		write_all(-6963, 7373, -7782, -1638, 410, 410, 3);
		send_step(0); send_step(0);
		drain();
		// Start point changed mid-run takes effect only at the end of the run.
		write_reg(REG_START_X, -12345);
		send_step(0); send_step(0); send_step(0);
		drain();
		// Count at the ceiling and above it.
		write_reg(REG_POINT_COUNT, 262144);
		send_step(0);
		drain();
		write_reg(REG_POINT_COUNT, 19'h7FFFF);
		send_step(1); send_step(0);
		drain();

		// Random walks over four idling patterns.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			for (int blk = 0; blk < 8; blk++) begin
				cnt = ($urandom_range(9) == 0) ? int'($urandom_range(19'h7FFFF))
					: int'($urandom_range(30));
				if ($urandom_range(3) == 0)
					write_reg(REG_START_Y, rand16());
				else
					write_all(rand16(), rand16(), rand16(), rand16(), rand16(), rand16(), cnt);
				for (int k = 0; k < 50; k++) begin
					if (ph == 0 && blk == 2 && k == 10) hold_off = 1;
					send_step($urandom_range(19) == 0);
				end
				drain();
			end
		end

		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
